### design/assert_macros.svh
// assertion macros shared by the checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define EFC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define EFC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/efc_pkg.sv
// types, constants and crc function for the event frame checker
package efc_pkg;

    localparam logic [14:0] SYNC_PATTERN  = 15'h3C5C;
    localparam logic [7:0]  CRC_POLY      = 8'h2F;
    localparam logic [16:0] CHIP_ID_RESET = 17'd109517;
    localparam logic [8:0]  HITS_MAX      = 9'd511;
    localparam logic [8:0]  HITS_BIG      = 9'd200;
    localparam logic [8:0]  HITS_FULL     = 9'd256;

    // word classification
    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_TRAILER = 3'd2,
        KIND_FILLER  = 3'd3,
        KIND_UNKNOWN = 3'd4,
        KIND_FOREIGN = 3'd5
    } t_kind;

    // what happened to the word
    typedef enum logic [2:0] {
        ACT_USED     = 3'd0,
        ACT_UNSYNCED = 3'd1,
        ACT_ORPHAN   = 3'd2,
        ACT_NO_HDR   = 3'd3,
        ACT_CUT      = 3'd4,
        ACT_IGNORED  = 3'd5
    } t_action;

    typedef struct packed {
        logic [39:0] frame_word;
        logic        end_of_stream;
    } t_frame_in;

    typedef struct packed {
        logic [2:0] frame_kind;
        logic [2:0] word_action;
        logic       event_done;
        logic       event_kept;
        logic       l1_jump;
        logic [7:0] l1_jump_size;
        logic       crc_error;
        logic [8:0] hits_expected;
        logic [8:0] hits_received;
        logic       ea_error;
        logic [1:0] header_type;
        logic [1:0] buffer_status;
    } t_verdict;

    typedef struct packed {
        logic       synced;
        logic       inside_event;
        logic       event_pending;
        logic       first_event;
        logic       expect_jump;
        logic [7:0] last_l1_count;
        logic [7:0] running_crc;
        logic [8:0] hit_count;
        logic       error_seen;
        logic [1:0] event_header_type;
        logic [7:0] trailer_hits;
        logic [1:0] trailer_buffer_status;
    } t_state;

    localparam t_state STATE_RESET = '{
        synced: 1'b0, inside_event: 1'b0, event_pending: 1'b0,
        first_event: 1'b1, expect_jump: 1'b0, last_l1_count: 8'd0,
        running_crc: 8'd0, hit_count: 9'd0, error_seen: 1'b0,
        event_header_type: 2'd0, trailer_hits: 8'd0,
        trailer_buffer_status: 2'd0
    };

    // msb-first crc-8 over one 40-bit word, flattens into an xor network
    function automatic logic [7:0] crc8_word(input logic [7:0] crc, input logic [39:0] w);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 39; i >= 0; i--) begin
            fb = c[7] ^ w[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

### design/efc_frame_if.sv
// request channel carrying frame words into the checker
interface efc_frame_if import efc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_frame_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/efc_verdict_if.sv
// request channel carrying one verdict per frame word
interface efc_verdict_if import efc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_verdict data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/efc_cfg_if.sv
// write channel for the expected chip id register
interface efc_cfg_if import efc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [16:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/efc_engine.sv
// classification, event tracking and verdict for one frame word
module efc_engine import efc_pkg::*; (
    input  t_frame_in   i_word,
    input  logic [16:0] i_chip_id,
    input  t_state      i_state,
    output t_state      o_state,
    output t_verdict    o_result
);

    logic [39:0] w;
    logic        is_sync;
    t_kind       kind;
    t_action     action;
    logic [7:0]  curr_l1;
    logic        skip_l1;
    logic        jump;
    logic [8:0]  exp_hits;
    t_state      ns;
    t_verdict    res;

    assign w       = i_word.frame_word;
    assign curr_l1 = w[21:14];

    // word classification
    always_comb begin
        is_sync = !w[39] && (w[38:24] == SYNC_PATTERN);
        if (w[39]) begin
            kind = KIND_DATA;
        end else if (is_sync && w[23:22] == 2'd0) begin
            kind = KIND_HEADER;
        end else if (is_sync && w[23:22] == 2'd2) begin
            kind = KIND_FILLER;
        end else if (!is_sync) begin
            kind = (w[38:22] == i_chip_id) ? KIND_TRAILER : KIND_FOREIGN;
        end else begin
            kind = KIND_UNKNOWN;
        end
    end

    // expected hits, a zero count with many hits means a full 256
    assign exp_hits = (i_state.trailer_hits == 8'd0 && i_state.hit_count >= HITS_BIG)
                      ? HITS_FULL : {1'b0, i_state.trailer_hits};

    // l1 continuity check for a header
    assign skip_l1 = i_state.first_event || i_state.expect_jump || i_state.inside_event;
    assign jump    = !skip_l1 && (curr_l1 != (i_state.last_l1_count + 8'd1));

    // state update and verdict
    always_comb begin
        ns     = i_state;
        res    = '0;
        action = ACT_IGNORED;
        if (i_word.end_of_stream) begin
            res.frame_kind = KIND_UNKNOWN;
            if (i_state.event_pending) begin
                res.event_done = 1'b1;
                res.event_kept = 1'b1;
                ns.event_pending = 1'b0;
            end
            action = i_state.inside_event ? ACT_CUT : ACT_IGNORED;
            ns.inside_event = 1'b0;
        end else begin
            res.frame_kind = kind;
            if (!i_state.synced && kind != KIND_HEADER) begin
                action = ACT_UNSYNCED;
            end else begin
                ns.synced = 1'b1;
                case (kind)
                    KIND_DATA: begin
                        if (!i_state.inside_event) begin
                            action = ACT_ORPHAN;
                        end else begin
                            action = ACT_USED;
                            if (i_state.hit_count != HITS_MAX) begin
                                ns.hit_count = i_state.hit_count + 9'd1;
                            end
                            if (w[38]) begin
                                ns.error_seen = 1'b1;
                            end
                            ns.running_crc = crc8_word(i_state.running_crc, w);
                        end
                    end
                    KIND_HEADER: begin
                        action = i_state.inside_event ? ACT_CUT : ACT_USED;
                        if (jump) begin
                            res.l1_jump      = 1'b1;
                            res.l1_jump_size = curr_l1 - i_state.last_l1_count;
                        end
                        if (i_state.event_pending) begin
                            res.event_done   = 1'b1;
                            res.event_kept   = !jump;
                            ns.event_pending = 1'b0;
                        end
                        ns.first_event       = 1'b0;
                        ns.expect_jump       = 1'b0;
                        ns.last_l1_count     = curr_l1;
                        ns.inside_event      = 1'b1;
                        ns.hit_count         = 9'd0;
                        ns.error_seen        = 1'b0;
                        ns.event_header_type = w[13:12];
                        ns.running_crc       = crc8_word(8'd0, w);
                    end
                    KIND_TRAILER: begin
                        if (!i_state.inside_event) begin
                            action = ACT_NO_HDR;
                        end else begin
                            action = ACT_USED;
                            ns.running_crc           = crc8_word(i_state.running_crc, w);
                            ns.trailer_hits          = w[15:8];
                            ns.trailer_buffer_status = w[21:20];
                            ns.event_pending         = 1'b1;
                            ns.inside_event          = 1'b0;
                        end
                    end
                    default: begin
                        action = ACT_IGNORED;
                    end
                endcase
            end
        end
        // fields of the resolved event come from the state before this word
        if (res.event_done) begin
            res.crc_error     = (i_state.running_crc != 8'd0);
            res.hits_expected = exp_hits;
            res.hits_received = i_state.hit_count;
            res.ea_error      = i_state.error_seen;
            res.header_type   = i_state.event_header_type;
            res.buffer_status = i_state.trailer_buffer_status;
        end
        res.word_action = action;
    end

    assign o_state  = ns;
    assign o_result = res;

endmodule

### design/event_frame_crc8_checker.sv
// top level of the event frame checker with crc-8 verdicts
//
// i_frame carries one request per 40-bit frame word, or an end-of-stream
// marker that flushes a pending event and closes an open one. o_verdict
// gives exactly one verdict per request, in order: word kind, word action,
// l1 continuity, and for an event resolved by this word its crc error, hit
// counts, error summary, header type and buffer status. i_cfg writes the
// expected trailer chip id; it is always ready.
// A request accepted into the input register passes the classify and crc
// logic and lands in the verdict register once that register is free, and
// the verdict can then be taken from there. Throughput is one word per
// cycle while the receiver takes every verdict; the 40-bit crc update and the
// event state advance in the single stage between those two registers.
// Reset clears the event state, drops any held words and loads the chip id
// default. When the receiver stalls, the verdict register holds and the
// input register still takes one more word; after that i_frame.ready drops
// until the verdict is taken.
`include "assert_macros.svh"

module event_frame_crc8_checker import efc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    efc_cfg_if.sink              i_cfg,
    efc_frame_if.sink            i_frame,
    efc_verdict_if.source        o_verdict
);

    logic        r_in_valid;
    logic        n_in_valid;
    t_frame_in   r_in;
    logic        r_out_valid;
    logic        n_out_valid;
    t_verdict    r_out;
    t_state      r_state;
    logic [16:0] r_chip_id;

    logic        w_advance;
    t_state      w_next_state;
    t_verdict    w_result;

    // handshake control
    assign w_advance     = r_in_valid && (!r_out_valid || o_verdict.ready);
    assign i_frame.ready = !r_in_valid || w_advance;
    assign i_cfg.ready   = 1'b1;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_frame.valid && i_frame.ready) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (o_verdict.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // per-word logic
    efc_engine u_engine (
        .i_word   (r_in),
        .i_chip_id(r_chip_id),
        .i_state  (r_state),
        .o_state  (w_next_state),
        .o_result (w_result)
    );

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_chip_id   <= CHIP_ID_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_state <= w_next_state;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_chip_id <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_in <= i_frame.data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_verdict.valid = r_out_valid;
    assign o_verdict.data  = r_out;

    // checks
    `EFC_ASSERT(a_open_or_pending, !(r_state.inside_event && r_state.event_pending),
        "event both open and pending")
    `EFC_ASSERT(a_unsynced_idle,
        !r_state.synced |-> (!r_state.inside_event && !r_state.event_pending),
        "event state before sync")
    `EFC_ASSERT(a_no_event_fields,
        (r_out_valid && !r_out.event_done) |-> (!r_out.event_kept && !r_out.crc_error &&
            r_out.hits_expected == 9'd0 && r_out.hits_received == 9'd0),
        "event fields without a resolved event")
    `EFC_ASSERT(a_jump_size,
        (r_out_valid && !r_out.l1_jump) |-> (r_out.l1_jump_size == 8'd0),
        "jump size without jump")
    `EFC_ASSERT(a_advance_fills, w_advance |=> r_out_valid, "verdict lost after advance")

endmodule
